// File: src/dtr_pkg.sv
// shared codes, register map and widths for the deadline timer register block
package dtr_pkg;

    // payload widths
    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 4;
    localparam int INDEX_W  = 3;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 64;
    localparam int IRQ_W    = 8;

    // position of the irq mode field in the config word
    localparam int CONFIG_IRQ_SHIFT = 8;

    // transaction function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // register map
    localparam logic [ADDR_W-1:0] ADDR_COUNT     = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_RELOAD    = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_CONFIG    = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_CONTROL   = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_RTC_LO    = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_RTC_HI    = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_LATCH     = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_PERIODIC  = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE    = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_PENDING   = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_DL_ABS    = 4'd10;
    localparam logic [ADDR_W-1:0] ADDR_DL_SET    = 4'd11;
    localparam logic [ADDR_W-1:0] ADDR_DL_ADD    = 4'd12;
    localparam logic [ADDR_W-1:0] ADDR_DL_PERIOD = 4'd13;

    // control word bits
    localparam int CTL_RUN    = 0;
    localparam int CTL_EN_ABS = 1;
    localparam int CTL_EN_SET = 2;
    localparam int CTL_EN_ADD = 3;

    // per-deadline pending command
    typedef enum logic [1:0] {
        CMD_COMPARE = 2'd0,
        CMD_SET     = 2'd1,
        CMD_ADD     = 2'd2,
        CMD_PERIOD  = 2'd3
    } cmd_t;

endpackage

// File: src/dtr_if.sv
// request and response channel interfaces of the deadline timer register block
interface dtr_req_if;
    import dtr_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   reg_addr;
    logic [INDEX_W-1:0]  deadline_index;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output func, output reg_addr, output deadline_index,
                    output write_data, input ready);
    modport sink   (input valid, input func, input reg_addr, input deadline_index,
                    input write_data, output ready);
endinterface

interface dtr_rsp_if;
    import dtr_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   read_data;
    logic                access_ok;
    logic [IRQ_W-1:0]    irq_lines;
    logic                irq_any;

    modport source (output valid, output read_data, output access_ok, output irq_lines,
                    output irq_any, input ready);
    modport sink   (input valid, input read_data, input access_ok, input irq_lines,
                    input irq_any, output ready);
endinterface

// File: src/deadline_timer_registers_unit.sv
// deadline timer: prescaled 64-bit counter, deadline comparators and register file
// a request transaction passes the input register, then the result register, to the response
// throughput: one transaction per cycle if response is taken; a tick updates all deadlines in parallel
// the response register stage lets a new request enter while a result waits
// reset (async, active low): counter, prescaler, masks, latch, operand and all deadlines
// clear to zero, every deadline command returns to compare
module deadline_timer_registers_unit #(
    parameter int DEADLINES = 8,
    parameter int IRQ_SPLIT = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    dtr_req_if.sink    request,
    dtr_rsp_if.source  response
);
    import dtr_pkg::*;

    localparam int IDX_W = (DEADLINES > 1) ? $clog2(DEADLINES) : 1;
    localparam logic [DATA_W-1:0] CONFIG_WORD =
        DATA_W'(DEADLINES) | (DATA_W'(IRQ_SPLIT) << CONFIG_IRQ_SHIFT);

    // input register stage
    logic                s1_valid_reg;
    logic [FUNC_W-1:0]   s1_func_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [INDEX_W-1:0]  s1_idx_reg;
    logic [DATA_W-1:0]   s1_data_reg;

    // response register stage
    logic                rsp_valid_reg;
    logic [DATA_W-1:0]   rsp_data_reg;
    logic                rsp_ok_reg;
    logic [IRQ_W-1:0]    rsp_irq_reg;
    logic                rsp_any_reg;

    // timer state
    logic [DATA_W-1:0]    pcount_reg,  pcount_next;
    logic [DATA_W-1:0]    preload_reg, preload_next;
    logic [DATA_W-1:0]    ctl_reg,     ctl_next;
    logic [COUNT_W-1:0]   rtc_reg,     rtc_next;
    logic [DATA_W-1:0]    latch_reg,   latch_next;
    logic [DEADLINES-1:0] periodic_reg, periodic_next;
    logic [DEADLINES-1:0] en_reg,      en_next;
    logic [DEADLINES-1:0] pend_reg,    pend_next;
    logic [DATA_W-1:0]    operand_reg, operand_next;
    logic [COUNT_W-1:0]   dl_reg     [DEADLINES];
    logic [COUNT_W-1:0]   dl_next    [DEADLINES];
    logic [DATA_W-1:0]    period_reg [DEADLINES];
    logic [DATA_W-1:0]    period_next[DEADLINES];
    cmd_t                 cmd_reg    [DEADLINES];
    cmd_t                 cmd_next   [DEADLINES];

    logic                 in_fire;
    logic                 proc_fire;
    logic [DATA_W-1:0]    idx_wide;
    logic                 idx_in_range;
    logic [IDX_W-1:0]     idx_sel;
    logic [DATA_W-1:0]    rd_value;
    logic                 ok_value;
    logic [DATA_W-1:0]    pend_wide;

    // handshake and pipeline flow
    assign proc_fire     = s1_valid_reg && (!rsp_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || proc_fire;
    assign in_fire       = request.valid && request.ready;

    // deadline index decode
    assign idx_wide     = DATA_W'(s1_idx_reg);
    assign idx_in_range = idx_wide < DATA_W'(DEADLINES);
    assign idx_sel      = idx_wide[IDX_W-1:0];

    // transaction processing: tick, register write, register read
    always_comb
    begin
        pcount_next   = pcount_reg;
        preload_next  = preload_reg;
        ctl_next      = ctl_reg;
        rtc_next      = rtc_reg;
        latch_next    = latch_reg;
        periodic_next = periodic_reg;
        en_next       = en_reg;
        pend_next     = pend_reg;
        operand_next  = operand_reg;
        dl_next       = dl_reg;
        period_next   = period_reg;
        cmd_next      = cmd_reg;
        rd_value      = '0;
        ok_value      = 1'b0;

        if (proc_fire)
        begin
            unique case (s1_func_reg)
                FUNC_TICK:
                begin
                    // prescaler and counter
                    if (ctl_reg[CTL_RUN])
                    begin
                        if (pcount_reg != '0)
                        begin
                            pcount_next = pcount_reg - DATA_W'(1);
                        end
                        else
                        begin
                            pcount_next = preload_reg;
                            rtc_next    = rtc_reg + COUNT_W'(1);
                        end
                    end
                    // each deadline compares or runs its pending command
                    for (int i = 0; i < DEADLINES; i++)
                    begin
                        unique case (cmd_reg[i])
                            CMD_COMPARE:
                            begin
                                if (rtc_reg >= dl_reg[i])
                                begin
                                    if (en_reg[i])
                                    begin
                                        pend_next[i] = 1'b1;
                                    end
                                    if (periodic_reg[i])
                                    begin
                                        cmd_next[i] = CMD_PERIOD;
                                    end
                                    else
                                    begin
                                        en_next[i] = 1'b0;
                                    end
                                end
                            end
                            CMD_SET:
                            begin
                                dl_next[i]  = rtc_reg + COUNT_W'(operand_reg);
                                cmd_next[i] = CMD_COMPARE;
                                if (ctl_reg[CTL_EN_SET])
                                begin
                                    en_next[i] = 1'b1;
                                end
                            end
                            CMD_ADD:
                            begin
                                dl_next[i]  = dl_reg[i]
                                            + {{(COUNT_W-DATA_W){operand_reg[DATA_W-1]}},
                                               operand_reg};
                                cmd_next[i] = CMD_COMPARE;
                                if (ctl_reg[CTL_EN_ADD])
                                begin
                                    en_next[i] = 1'b1;
                                end
                            end
                            CMD_PERIOD:
                            begin
                                dl_next[i]  = dl_reg[i] + COUNT_W'(period_reg[i]);
                                cmd_next[i] = CMD_COMPARE;
                            end
                        endcase
                    end
                end
                FUNC_WRITE:
                begin
                    if (s1_addr_reg >= ADDR_DL_ABS)
                    begin
                        // per-deadline fields
                        if (idx_in_range)
                        begin
                            ok_value = 1'b1;
                            unique case (s1_addr_reg)
                                ADDR_DL_ABS:
                                begin
                                    dl_next[idx_sel] = {latch_reg, s1_data_reg};
                                    if (ctl_reg[CTL_EN_ABS])
                                    begin
                                        en_next[idx_sel] = 1'b1;
                                    end
                                end
                                ADDR_DL_SET:
                                begin
                                    cmd_next[idx_sel] = CMD_SET;
                                    operand_next      = s1_data_reg;
                                end
                                ADDR_DL_ADD:
                                begin
                                    cmd_next[idx_sel] = CMD_ADD;
                                    operand_next      = s1_data_reg;
                                end
                                ADDR_DL_PERIOD:
                                begin
                                    period_next[idx_sel] = s1_data_reg;
                                end
                                default:
                                begin
                                    ok_value = 1'b0;
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        // global registers
                        ok_value = 1'b1;
                        unique case (s1_addr_reg)
                            ADDR_COUNT:    pcount_next   = s1_data_reg;
                            ADDR_RELOAD:   preload_next  = s1_data_reg;
                            ADDR_CONTROL:  ctl_next      = s1_data_reg;
                            ADDR_LATCH:    latch_next    = s1_data_reg;
                            ADDR_PERIODIC: periodic_next = s1_data_reg[DEADLINES-1:0];
                            ADDR_ENABLE:   en_next       = s1_data_reg[DEADLINES-1:0];
                            ADDR_PENDING:  pend_next     = pend_reg & ~s1_data_reg[DEADLINES-1:0];
                            default:       ok_value      = 1'b0;
                        endcase
                    end
                end
                FUNC_READ:
                begin
                    if (s1_addr_reg >= ADDR_DL_ABS)
                    begin
                        // per-deadline fields; low half read latches the high half
                        if (idx_in_range)
                        begin
                            unique case (s1_addr_reg)
                                ADDR_DL_ABS:
                                begin
                                    ok_value   = 1'b1;
                                    rd_value   = dl_reg[idx_sel][DATA_W-1:0];
                                    latch_next = dl_reg[idx_sel][COUNT_W-1:DATA_W];
                                end
                                ADDR_DL_PERIOD:
                                begin
                                    ok_value = 1'b1;
                                    rd_value = period_reg[idx_sel];
                                end
                                default:
                                begin
                                    ok_value = 1'b0;
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        // global registers; counter halves latch the other half
                        ok_value = 1'b1;
                        unique case (s1_addr_reg)
                            ADDR_COUNT:    rd_value = pcount_reg;
                            ADDR_RELOAD:   rd_value = preload_reg;
                            ADDR_CONFIG:   rd_value = CONFIG_WORD;
                            ADDR_CONTROL:  rd_value = ctl_reg;
                            ADDR_RTC_LO:
                            begin
                                rd_value   = rtc_reg[DATA_W-1:0];
                                latch_next = rtc_reg[COUNT_W-1:DATA_W];
                            end
                            ADDR_RTC_HI:
                            begin
                                rd_value   = rtc_reg[COUNT_W-1:DATA_W];
                                latch_next = rtc_reg[DATA_W-1:0];
                            end
                            ADDR_LATCH:    rd_value = latch_reg;
                            ADDR_PERIODIC: rd_value = DATA_W'(periodic_reg);
                            ADDR_ENABLE:   rd_value = DATA_W'(en_reg);
                            ADDR_PENDING:  rd_value = DATA_W'(pend_reg);
                            default:       ok_value = 1'b0;
                        endcase
                    end
                end
                default:
                begin
                    ok_value = 1'b0;
                end
            endcase
        end
    end

    assign pend_wide = DATA_W'(pend_next);

    // control state and timer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pcount_reg    <= '0;
            preload_reg   <= '0;
            ctl_reg       <= '0;
            rtc_reg       <= '0;
            latch_reg     <= '0;
            periodic_reg  <= '0;
            en_reg        <= '0;
            pend_reg      <= '0;
            operand_reg   <= '0;
            for (int i = 0; i < DEADLINES; i++)
            begin
                dl_reg[i]     <= '0;
                period_reg[i] <= '0;
                cmd_reg[i]    <= CMD_COMPARE;
            end
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (proc_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            pcount_reg   <= pcount_next;
            preload_reg  <= preload_next;
            ctl_reg      <= ctl_next;
            rtc_reg      <= rtc_next;
            latch_reg    <= latch_next;
            periodic_reg <= periodic_next;
            en_reg       <= en_next;
            pend_reg     <= pend_next;
            operand_reg  <= operand_next;
            dl_reg       <= dl_next;
            period_reg   <= period_next;
            cmd_reg      <= cmd_next;
        end
    end

    // payload registers of both stages
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= request.func;
            s1_addr_reg <= request.reg_addr;
            s1_idx_reg  <= request.deadline_index;
            s1_data_reg <= request.write_data;
        end
        if (proc_fire)
        begin
            rsp_data_reg <= rd_value;
            rsp_ok_reg   <= ok_value;
            rsp_irq_reg  <= pend_wide[IRQ_W-1:0];
            rsp_any_reg  <= |pend_next;
        end
    end

    // response channel
    assign response.valid     = rsp_valid_reg;
    assign response.read_data = rsp_data_reg;
    assign response.access_ok = rsp_ok_reg;
    assign response.irq_lines = rsp_irq_reg;
    assign response.irq_any   = rsp_any_reg;

    // counter moves only on a processed tick
    assert property (@(posedge clk) disable iff (!rst_n)
        !(proc_fire && (s1_func_reg == FUNC_TICK)) |=> $stable(rtc_reg))
        else $error("counter changed without a tick");

    // irq summary follows the pending bits just written
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> (rsp_valid_reg && (rsp_any_reg == (|pend_reg))))
        else $error("irq summary out of step with pending bits");

    // a tick returns no data and no access status
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && (s1_func_reg == FUNC_TICK)) |=> (!rsp_ok_reg && (rsp_data_reg == '0)))
        else $error("tick produced read data or access status");

    // request side never stalls while the response register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> request.ready)
        else $error("request stalled with empty response register");

endmodule

// File: tb/deadline_timer_registers_unit_tb.sv
// self-checking testbench for the deadline timer register block
`timescale 1ns / 100ps

module deadline_timer_registers_unit_tb;
    import dtr_pkg::*;

    localparam int NUM_DL  = 8;
    localparam int SEP_IRQ = 0;

    // function code with no meaning, and the two unmapped addresses
    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_HOLE_LO = 4'd14;
    localparam logic [ADDR_W-1:0] ADDR_HOLE_HI = 4'd15;

    localparam logic [DATA_W-1:0] CONFIG_WORD = 32'(NUM_DL) | (32'(SEP_IRQ) << CONFIG_IRQ_SHIFT);
    localparam logic [DATA_W-1:0] CTL_ALL_ON  =
        (32'd1 << CTL_RUN) | (32'd1 << CTL_EN_ABS) | (32'd1 << CTL_EN_SET) | (32'd1 << CTL_EN_ADD);
    localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

    localparam int RANDOM_REQUESTS = 450;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int HOLD_OFF_CYCLES = 120;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  reg_addr;
        logic [INDEX_W-1:0] deadline_index;
        logic [DATA_W-1:0]  write_data;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_ok;
        logic [IRQ_W-1:0]  irq_lines;
        logic              irq_any;
    } status_t;

    typedef struct packed {
        request_t          req;
        logic              typed;
        logic [DATA_W-1:0] read_data;
        logic              access_ok;
    } directed_row_t;

    localparam int N_DIRECTED = 28;

    // directed requests; read_data and access_ok are given where typed is set
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{FUNC_READ,   ADDR_CONFIG,    3'd0, 32'd0},      1'b1, CONFIG_WORD, 1'b1},
        '{'{FUNC_READ,   ADDR_COUNT,     3'd0, 32'd0},      1'b1, 32'd0,       1'b1},
        '{'{FUNC_READ,   ADDR_RTC_HI,    3'd0, 32'd0},      1'b1, 32'd0,       1'b1},
        '{'{FUNC_READ,   ADDR_HOLE_LO,   3'd7, 32'd0},      1'b1, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_HOLE_HI,   3'd0, ALL_ONES},   1'b1, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_CONFIG,    3'd0, ALL_ONES},   1'b1, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_RTC_LO,    3'd0, ALL_ONES},   1'b1, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_RTC_HI,    3'd0, ALL_ONES},   1'b1, 32'd0,       1'b0},
        '{'{FUNC_READ,   ADDR_DL_SET,    3'd7, 32'd0},      1'b1, 32'd0,       1'b0},
        '{'{FUNC_READ,   ADDR_DL_ADD,    3'd0, 32'd0},      1'b1, 32'd0,       1'b0},
        '{'{FUNC_UNUSED, ADDR_CONTROL,   3'd0, ALL_ONES},   1'b1, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_LATCH,     3'd0, ALL_ONES},   1'b1, 32'd0,       1'b1},
        '{'{FUNC_READ,   ADDR_LATCH,     3'd0, 32'd0},      1'b1, ALL_ONES,    1'b1},
        '{'{FUNC_WRITE,  ADDR_PERIODIC,  3'd0, ALL_ONES},   1'b1, 32'd0,       1'b1},
        '{'{FUNC_READ,   ADDR_PERIODIC,  3'd0, 32'd0},      1'b1, 32'h0000_00FF, 1'b1},
        '{'{FUNC_WRITE,  ADDR_PERIODIC,  3'd0, 32'd2},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_LATCH,     3'd0, 32'd0},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_CONTROL,   3'd0, CTL_ALL_ON}, 1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_DL_ABS,    3'd0, 32'd3},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_DL_SET,    3'd1, 32'd2},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_DL_ADD,    3'd2, ALL_ONES},   1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_DL_PERIOD, 3'd1, 32'd4},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_READ,   ADDR_DL_PERIOD, 3'd1, 32'd0},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_TICK,   ADDR_COUNT,     3'd0, 32'd0},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_TICK,   ADDR_HOLE_HI,   3'd7, ALL_ONES},   1'b0, 32'd0,       1'b0},
        '{'{FUNC_READ,   ADDR_RTC_LO,    3'd0, 32'd0},      1'b0, 32'd0,       1'b0},
        '{'{FUNC_WRITE,  ADDR_PENDING,   3'd0, ALL_ONES},   1'b0, 32'd0,       1'b0},
        '{'{FUNC_READ,   ADDR_DL_ABS,    3'd7, 32'd0},      1'b1, 32'd0,       1'b1}
    };

    logic clk;
    logic rst_n;
    logic hold_off;

    dtr_req_if req_ch ();
    dtr_rsp_if rsp_ch ();

    deadline_timer_registers_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // timer state as the block should hold it
    logic [DATA_W-1:0]  pre_cnt;
    logic [DATA_W-1:0]  pre_reload;
    logic [DATA_W-1:0]  ctl;
    logic [COUNT_W-1:0] rtc;
    logic [DATA_W-1:0]  hi_latch;
    logic [IRQ_W-1:0]   per_mask;
    logic [IRQ_W-1:0]   en_mask;
    logic [IRQ_W-1:0]   pend_mask;
    logic [DATA_W-1:0]  shared_operand;
    logic [COUNT_W-1:0] dl_value [NUM_DL];
    logic [DATA_W-1:0]  dl_period [NUM_DL];
    cmd_t               dl_cmd [NUM_DL];

    status_t expected_status_q [$];
    int      requests_sent;
    int      mismatches;

    // applies one transaction to the timer state and returns the status it yields
    // (the 3-bit index always names an existing deadline)
    function automatic status_t predict_status(input request_t r);
        status_t            s;
        logic [COUNT_W-1:0] old_rtc;
        logic [IRQ_W-1:0]   old_en;
        logic [IRQ_W-1:0]   new_en;
        logic [IRQ_W-1:0]   new_pend;
        s = '0;
        case (r.func)
            FUNC_TICK:
            begin
                // every decision of a tick uses the values from before it
                old_rtc  = rtc;
                old_en   = en_mask;
                new_en   = en_mask;
                new_pend = pend_mask;
                if (ctl[CTL_RUN])
                begin
                    if (pre_cnt != 0)
                        pre_cnt = pre_cnt - 32'd1;
                    else
                    begin
                        pre_cnt = pre_reload;
                        rtc     = old_rtc + 64'd1;
                    end
                end
                for (int i = 0; i < NUM_DL; i++)
                begin
                    case (dl_cmd[i])
                        CMD_COMPARE:
                        begin
                            if (old_rtc >= dl_value[i])
                            begin
                                if (old_en[i])
                                    new_pend[i] = 1'b1;
                                if (per_mask[i])
                                    dl_cmd[i] = CMD_PERIOD;
                                else
                                    new_en[i] = 1'b0;
                            end
                        end
                        CMD_SET:
                        begin
                            dl_value[i] = old_rtc + {32'd0, shared_operand};
                            dl_cmd[i]   = CMD_COMPARE;
                            if (ctl[CTL_EN_SET])
                                new_en[i] = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            dl_value[i] = dl_value[i]
                                + {{32{shared_operand[31]}}, shared_operand};
                            dl_cmd[i]   = CMD_COMPARE;
                            if (ctl[CTL_EN_ADD])
                                new_en[i] = 1'b1;
                        end
                        default:
                        begin
                            dl_value[i] = dl_value[i] + {32'd0, dl_period[i]};
                            dl_cmd[i]   = CMD_COMPARE;
                        end
                    endcase
                end
                en_mask   = new_en;
                pend_mask = new_pend;
            end
            FUNC_WRITE:
            begin
                s.access_ok = 1'b1;
                case (r.reg_addr)
                    ADDR_COUNT:     pre_cnt    = r.write_data;
                    ADDR_RELOAD:    pre_reload = r.write_data;
                    ADDR_CONTROL:   ctl        = r.write_data;
                    ADDR_LATCH:     hi_latch   = r.write_data;
                    ADDR_PERIODIC:  per_mask   = r.write_data[IRQ_W-1:0];
                    ADDR_ENABLE:    en_mask    = r.write_data[IRQ_W-1:0];
                    ADDR_PENDING:   pend_mask  = pend_mask & ~r.write_data[IRQ_W-1:0];
                    ADDR_DL_ABS:
                    begin
                        dl_value[r.deadline_index] = {hi_latch, r.write_data};
                        if (ctl[CTL_EN_ABS])
                            en_mask[r.deadline_index] = 1'b1;
                    end
                    ADDR_DL_SET:
                    begin
                        dl_cmd[r.deadline_index] = CMD_SET;
                        shared_operand           = r.write_data;
                    end
                    ADDR_DL_ADD:
                    begin
                        dl_cmd[r.deadline_index] = CMD_ADD;
                        shared_operand           = r.write_data;
                    end
                    ADDR_DL_PERIOD: dl_period[r.deadline_index] = r.write_data;
                    default:        s.access_ok = 1'b0;
                endcase
            end
            FUNC_READ:
            begin
                s.access_ok = 1'b1;
                case (r.reg_addr)
                    ADDR_COUNT:     s.read_data = pre_cnt;
                    ADDR_RELOAD:    s.read_data = pre_reload;
                    ADDR_CONFIG:    s.read_data = CONFIG_WORD;
                    ADDR_CONTROL:   s.read_data = ctl;
                    ADDR_RTC_LO:
                    begin
                        s.read_data = rtc[31:0];
                        hi_latch    = rtc[63:32];
                    end
                    ADDR_RTC_HI:
                    begin
                        s.read_data = rtc[63:32];
                        hi_latch    = rtc[31:0];
                    end
                    ADDR_LATCH:     s.read_data = hi_latch;
                    ADDR_PERIODIC:  s.read_data = {24'd0, per_mask};
                    ADDR_ENABLE:    s.read_data = {24'd0, en_mask};
                    ADDR_PENDING:   s.read_data = {24'd0, pend_mask};
                    ADDR_DL_ABS:
                    begin
                        s.read_data = dl_value[r.deadline_index][31:0];
                        hi_latch    = dl_value[r.deadline_index][63:32];
                    end
                    ADDR_DL_PERIOD: s.read_data = dl_period[r.deadline_index];
                    default:        s.access_ok = 1'b0;
                endcase
            end
            default: ;
        endcase
        s.irq_lines = pend_mask;
        s.irq_any   = |pend_mask;
        return s;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // mostly well-formed timer programming and ticks, with some raw noise
    function automatic request_t random_request();
        request_t r;
        int       roll;
        logic [DATA_W-1:0] d;
        roll             = $urandom_range(0, 99);
        r.func           = FUNC_WRITE;
        r.reg_addr       = ADDR_COUNT;
        r.deadline_index = 3'($urandom_range(0, NUM_DL - 1));
        r.write_data     = 32'($urandom_range(0, 20));
        if (roll < 45)
        begin
            r.func       = FUNC_TICK;
            r.reg_addr   = 4'($urandom_range(0, 15));
            r.write_data = $urandom();
        end
        else if (roll < 55)
        begin
            r.reg_addr = ADDR_DL_SET;
            if ($urandom_range(0, 9) == 0)
                r.write_data = $urandom();
        end
        else if (roll < 60)
        begin
            // small signed step either way
            r.reg_addr   = ADDR_DL_ADD;
            r.write_data = 32'($urandom_range(0, 40)) - 32'd20;
        end
        else if (roll < 63)
        begin
            r.reg_addr   = ADDR_DL_PERIOD;
            r.write_data = 32'($urandom_range(0, 15));
        end
        else if (roll < 66)
        begin
            r.reg_addr   = ADDR_DL_ABS;
            r.write_data = 32'($urandom_range(0, 150));
        end
        else if (roll < 69)
        begin
            d          = $urandom();
            d[CTL_RUN] = ($urandom_range(0, 9) != 0);
            r.reg_addr   = ADDR_CONTROL;
            r.write_data = d;
        end
        else if (roll < 71)
        begin
            r.reg_addr   = ADDR_ENABLE;
            r.write_data = $urandom();
        end
        else if (roll < 73)
        begin
            r.reg_addr   = ADDR_PERIODIC;
            r.write_data = $urandom();
        end
        else if (roll < 76)
        begin
            r.reg_addr   = ADDR_PENDING;
            r.write_data = $urandom();
        end
        else if (roll < 78)
        begin
            r.reg_addr   = ADDR_RELOAD;
            r.write_data = 32'($urandom_range(0, 3));
        end
        else if (roll < 79)
        begin
            r.reg_addr   = ADDR_COUNT;
            r.write_data = 32'($urandom_range(0, 5));
        end
        else if (roll < 80)
        begin
            r.reg_addr   = ADDR_LATCH;
            r.write_data = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom());
        end
        else if (roll < 93)
        begin
            r.func     = FUNC_READ;
            r.reg_addr = 4'($urandom_range(0, 15));
        end
        else
        begin
            r.func           = 2'($urandom_range(0, 3));
            r.reg_addr       = 4'($urandom_range(0, 15));
            r.deadline_index = 3'($urandom_range(0, 7));
            r.write_data     = $urandom();
        end
        return r;
    endfunction

    // offer one transaction, record its prediction once accepted, then idle
    task automatic send_request(input request_t r, input logic typed,
                                input logic [DATA_W-1:0] typed_data, input logic typed_ok);
        status_t s;
        int      gap;
        req_ch.valid          <= 1'b1;
        req_ch.func           <= r.func;
        req_ch.reg_addr       <= r.reg_addr;
        req_ch.deadline_index <= r.deadline_index;
        req_ch.write_data     <= r.write_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        s = predict_status(r);
        if (typed)
        begin
            s.read_data = typed_data;
            s.access_ok = typed_ok;
        end
        expected_status_q.push_back(s);
        requests_sent++;
        gap = pick_gap((requests_sent % 100) < 20);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one long hold-off on the response side while requests keep coming
    initial
    begin
        hold_off <= 1'b0;
        wait (requests_sent >= HOLD_OFF_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // response side: random stalls, compare each transaction with the oldest prediction
    initial
    begin
        int      stall_left;
        int      cycles;
        status_t exp;
        stall_left = 0;
        cycles     = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response with nothing expected: read_data %h ok %b irq %h any %b",
                                 rsp_ch.read_data, rsp_ch.access_ok, rsp_ch.irq_lines,
                                 rsp_ch.irq_any);
                end
                else
                begin
                    exp = expected_status_q.pop_front();
                    if (rsp_ch.read_data !== exp.read_data || rsp_ch.access_ok !== exp.access_ok
                        || rsp_ch.irq_lines !== exp.irq_lines || rsp_ch.irq_any !== exp.irq_any)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"bad response: read_data %h/%h ok %b/%b irq %h/%h any %b/%b",
                                      " (expected/actual)"},
                                     exp.read_data, rsp_ch.read_data, exp.access_ok,
                                     rsp_ch.access_ok, exp.irq_lines, rsp_ch.irq_lines,
                                     exp.irq_any, rsp_ch.irq_any);
                    end
                end
            end
            cycles++;
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap((cycles % 256) < 48);
            rsp_ch.ready <= (stall_left == 0) && !hold_off;
        end
    end

    // reset, directed table, random traffic, drain
    initial
    begin
        request_t r;
        int       accepted;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= FUNC_TICK;
        req_ch.reg_addr       <= ADDR_COUNT;
        req_ch.deadline_index <= '0;
        req_ch.write_data     <= '0;
        requests_sent  = 0;
        mismatches     = 0;
        pre_cnt        = '0;
        pre_reload     = '0;
        ctl            = '0;
        rtc            = '0;
        hi_latch       = '0;
        per_mask       = '0;
        en_mask        = '0;
        pend_mask      = '0;
        shared_operand = '0;
        for (int i = 0; i < NUM_DL; i++)
        begin
            dl_value[i]  = '0;
            dl_period[i] = '0;
            dl_cmd[i]    = CMD_COMPARE;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                         DIRECTED_ROWS[i].read_data, DIRECTED_ROWS[i].access_ok);

        // ignored transactions do not count toward the random total
        accepted = 0;
        while (accepted < RANDOM_REQUESTS)
        begin
            r = random_request();
            send_request(r, 1'b0, '0, 1'b0);
            if (r.func != FUNC_UNUSED)
                accepted++;
        end
        req_ch.valid <= 1'b0;

        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("deadline_timer_registers_unit: match");
        else
            $display("deadline_timer_registers_unit: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("deadline_timer_registers_unit: mismatch");
        $finish;
    end

endmodule

// File: sim.f
src/dtr_pkg.sv
src/dtr_if.sv
src/deadline_timer_registers_unit.sv
tb/deadline_timer_registers_unit_tb.sv
